@@ rtl/bfa_pkg.sv @@
`default_nettype none
package bfa_pkg;

  localparam int SIZE_W = 17;
  localparam int OFFS_W = 16;
  localparam int STAT_W = 2;

  // Status codes reported with every result item.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // One block table entry.
  typedef struct packed {
    logic              valid;
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [OFFS_W-1:0] start;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [SIZE_W-1:0] largest;
    logic [OFFS_W-1:0] granted;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/bfa_table.sv @@
`default_nettype none
module bfa_table #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire [$clog2(MAX_BLOCKS)-1:0] waddr,
  input  bfa_pkg::entry_t              wdata,
  input  wire                          re,
  input  wire [$clog2(MAX_BLOCKS)-1:0] raddr,
  output bfa_pkg::entry_t              rdata
);

  bfa_pkg::entry_t mem [MAX_BLOCKS];
  bfa_pkg::entry_t rdata_r;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/bfa_ctrl.sv @@
`default_nettype none
module bfa_ctrl #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr,
  input  wire [bfa_pkg::SIZE_W-1:0]      pool,
  input  wire                            req_valid,
  output logic                           req_ready,
  input  wire                            req_cmd,
  input  wire [bfa_pkg::SIZE_W-1:0]      req_size,
  input  wire [bfa_pkg::OFFS_W-1:0]      req_offs,
  output logic                           res_valid,
  input  wire                            res_ready,
  output bfa_pkg::res_t                  res,
  output logic                           tbl_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]  tbl_waddr,
  output bfa_pkg::entry_t                tbl_wdata,
  output logic                           tbl_re,
  output logic [$clog2(MAX_BLOCKS)-1:0]  tbl_raddr,
  input  bfa_pkg::entry_t                tbl_rdata
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [IW:0] DEPTH = (IW+1)'(MAX_BLOCKS);
  localparam logic [IW:0] LAST  = (IW+1)'(MAX_BLOCKS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_WA, S_WB, S_DONE} state_t;
  typedef enum logic [1:0] {K_ALLOC, K_FIND, K_NEIGH, K_LARGEST} kind_t;

  state_t  state_r;
  kind_t   kind_r;
  logic [IW:0]   rd_cnt_r;
  logic          rvld_r;
  logic [IW-1:0] ridx_r;

  logic [bfa_pkg::SIZE_W-1:0] req_r;
  logic [bfa_pkg::OFFS_W-1:0] off_r;

  logic                       best_found_r;
  logic [IW-1:0]              best_idx_r;
  logic [bfa_pkg::SIZE_W-1:0] best_size_r;
  logic [bfa_pkg::OFFS_W-1:0] best_start_r;
  logic                       slot_found_r;
  logic [IW-1:0]              slot_idx_r;

  logic            cur_found_r;
  logic [IW-1:0]   cur_idx_r;
  bfa_pkg::entry_t cur_r;
  logic            nb1_found_r;
  logic [IW-1:0]   nb1_idx_r;
  bfa_pkg::entry_t nb1_r;
  logic            nb2_found_r;
  logic [IW-1:0]   nb2_idx_r;
  bfa_pkg::entry_t nb2_r;

  logic [bfa_pkg::SIZE_W-1:0] largest_r;
  logic [bfa_pkg::STAT_W-1:0] status_r;
  logic [bfa_pkg::OFFS_W-1:0] granted_r;

  logic            pa_v_r, pb_v_r;
  logic [IW-1:0]   pa_addr_r, pb_addr_r;
  bfa_pkg::entry_t pa_data_r, pb_data_r;

  logic                       scan_end;
  logic                       m1, m2;
  logic [bfa_pkg::SIZE_W-1:0] merged;
  logic [bfa_pkg::SIZE_W-1:0] cur_end;
  logic [bfa_pkg::SIZE_W-1:0] e_end;
  bfa_pkg::entry_t            e;
  bfa_pkg::entry_t            used_best;

  assign e         = tbl_rdata;
  assign scan_end  = (state_r == S_SCAN) && (rd_cnt_r == DEPTH) && !rvld_r;
  assign cur_end   = {1'b0, cur_r.start} + cur_r.size;
  assign e_end     = {1'b0, e.start} + e.size;
  assign m1        = nb1_found_r && nb1_r.free;
  assign m2        = nb2_found_r && nb2_r.free;
  assign merged    = cur_r.size + (m1 ? nb1_r.size : '0);
  assign used_best = '{valid: 1'b1, free: 1'b0, size: req_r, start: best_start_r};

  // Read side of a table sweep: one entry per cycle.
  assign tbl_re    = (state_r == S_SCAN) && (rd_cnt_r < DEPTH);
  assign tbl_raddr = rd_cnt_r[IW-1:0];

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{largest: largest_r, granted: granted_r, status: status_r};

  // Write side: clearing pass, writes decided at the end of a sweep, queued writes.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = rd_cnt_r[IW-1:0];
        if (rd_cnt_r == '0 && pool != '0) begin
          tbl_wdata = '{valid: 1'b1, free: 1'b1, size: pool, start: '0};
        end
      end
      S_SCAN: begin
        if (scan_end && kind_r == K_ALLOC && best_found_r) begin
          if (best_size_r == req_r) begin
            tbl_we    = 1'b1;
            tbl_waddr = best_idx_r;
            tbl_wdata = used_best;
          end else if (slot_found_r) begin
            tbl_we    = 1'b1;
            tbl_waddr = slot_idx_r;
            tbl_wdata = '{valid: 1'b1, free: 1'b1, size: best_size_r - req_r,
                          start: best_start_r + req_r[bfa_pkg::OFFS_W-1:0]};
          end
        end else if (scan_end && kind_r == K_NEIGH) begin
          tbl_we    = 1'b1;
          tbl_waddr = cur_idx_r;
          if (!m2) begin
            tbl_wdata = '{valid: 1'b1, free: 1'b1, size: merged, start: cur_r.start};
          end
        end
      end
      S_WA: begin
        tbl_we    = pa_v_r;
        tbl_waddr = pa_addr_r;
        tbl_wdata = pa_data_r;
      end
      S_WB: begin
        tbl_we    = pb_v_r;
        tbl_waddr = pb_addr_r;
        tbl_wdata = pb_data_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: state, sweep captures and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      rd_cnt_r <= '0;
      rvld_r   <= 1'b0;
    end else if (cfg_wr) begin
      state_r  <= S_CLEAR;
      rd_cnt_r <= '0;
      rvld_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
          if (rd_cnt_r == LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_r        <= req_size;
            off_r        <= req_offs;
            granted_r    <= '0;
            best_found_r <= 1'b0;
            slot_found_r <= 1'b0;
            cur_found_r  <= 1'b0;
            largest_r    <= '0;
            rd_cnt_r     <= '0;
            state_r      <= S_SCAN;
            if (req_cmd == bfa_pkg::CMD_FREE) begin
              status_r <= bfa_pkg::ST_OK;
              kind_r   <= K_FIND;
            end else if (req_size == '0) begin
              status_r <= bfa_pkg::ST_NOFIT;
              kind_r   <= K_LARGEST;
            end else begin
              status_r <= bfa_pkg::ST_OK;
              kind_r   <= K_ALLOC;
            end
          end
        end
        S_SCAN: begin
          rvld_r <= tbl_re;
          ridx_r <= tbl_raddr;
          if (tbl_re) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          // Compare the entry read in the previous cycle.
          if (rvld_r) begin
            unique case (kind_r)
              K_ALLOC: begin
                if (e.valid && e.free && e.size >= req_r &&
                    (!best_found_r || e.size < best_size_r ||
                     (e.size == best_size_r && e.start < best_start_r))) begin
                  best_found_r <= 1'b1;
                  best_idx_r   <= ridx_r;
                  best_size_r  <= e.size;
                  best_start_r <= e.start;
                end
                if (!e.valid && !slot_found_r) begin
                  slot_found_r <= 1'b1;
                  slot_idx_r   <= ridx_r;
                end
              end
              K_FIND: begin
                if (e.valid && e.start == off_r && !cur_found_r) begin
                  cur_found_r <= 1'b1;
                  cur_idx_r   <= ridx_r;
                  cur_r       <= e;
                end
              end
              K_NEIGH: begin
                if (e.valid && {1'b0, e.start} == cur_end && !nb1_found_r) begin
                  nb1_found_r <= 1'b1;
                  nb1_idx_r   <= ridx_r;
                  nb1_r       <= e;
                end
                if (e.valid && e_end == {1'b0, cur_r.start} && ridx_r != cur_idx_r &&
                    !nb2_found_r) begin
                  nb2_found_r <= 1'b1;
                  nb2_idx_r   <= ridx_r;
                  nb2_r       <= e;
                end
              end
              K_LARGEST: begin
                if (e.valid && e.free && e.size > largest_r) begin
                  largest_r <= e.size;
                end
              end
              default: begin
              end
            endcase
          end
          // Decide what follows a finished sweep.
          if (scan_end) begin
            rd_cnt_r <= '0;
            unique case (kind_r)
              K_ALLOC: begin
                kind_r <= K_LARGEST;
                if (!best_found_r) begin
                  status_r <= bfa_pkg::ST_NOFIT;
                end else if (best_size_r == req_r) begin
                  granted_r <= best_start_r;
                end else if (!slot_found_r) begin
                  status_r <= bfa_pkg::ST_FULL;
                end else begin
                  granted_r <= best_start_r;
                  pa_v_r    <= 1'b1;
                  pa_addr_r <= best_idx_r;
                  pa_data_r <= used_best;
                  pb_v_r    <= 1'b0;
                  state_r   <= S_WA;
                end
              end
              K_FIND: begin
                if (!cur_found_r || cur_r.free) begin
                  status_r <= bfa_pkg::ST_BAD_FREE;
                  kind_r   <= K_LARGEST;
                end else begin
                  kind_r      <= K_NEIGH;
                  nb1_found_r <= 1'b0;
                  nb2_found_r <= 1'b0;
                end
              end
              K_NEIGH: begin
                kind_r    <= K_LARGEST;
                pa_v_r    <= m1;
                pa_addr_r <= nb1_idx_r;
                pa_data_r <= '0;
                pb_v_r    <= m2;
                pb_addr_r <= nb2_idx_r;
                pb_data_r <= '{valid: 1'b1, free: 1'b1, size: nb2_r.size + merged,
                               start: nb2_r.start};
                state_r   <= S_WA;
              end
              K_LARGEST: begin
                state_r <= S_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        S_WA: begin
          state_r <= S_WB;
        end
        S_WB: begin
          state_r  <= S_SCAN;
          kind_r   <= K_LARGEST;
          rd_cnt_r <= '0;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/best_fit_block_allocator_top.sv @@
// Channel   Direction  Handshake                Contents
// in_       input      in_tvalid / in_tready    tuser: cmd; tdata: request_size, free_offset
// out_      output     out_tvalid / out_tready  tdata: status, granted_offset, largest_free
// cfg_      input      APB write / read         register 0 at address 0: pool_size
//
// One item at a time. An allocate runs a best-fit sweep of the table, the queued writes
// of a split and a sweep for the largest free block; a free runs a find sweep and, for a
// used block, a neighbour sweep, the queued merge writes and the largest sweep; a zero-size
// allocate runs the largest sweep alone. Each table sweep reads one entry per cycle
// through the single read port of the block table. After reset and after every pool_size
// write a clearing pass rewrites the table; in_tready stays low meanwhile.
// A result waits in the output register while the next item is taken; the next
// result waits in the controller until that register is free.
`default_nettype none
module best_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = 64,
  parameter int POOL_BYTES = 65536
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [16:0] request_size, [32:17] free_offset, rest zero
  input  wire  [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [17:2] granted_offset, [34:18] largest_free
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [31:0] POOL_LIM = 32'(POOL_BYTES);
  localparam logic [bfa_pkg::SIZE_W-1:0] POOL_RST =
    (POOL_LIM < 32'd65536) ? POOL_LIM[bfa_pkg::SIZE_W-1:0] : 17'd65536;

  logic [bfa_pkg::SIZE_W-1:0] pool_size_r;
  logic [bfa_pkg::SIZE_W-1:0] wr_val;
  logic                       cfg_wr;
  logic                       res_valid, res_ready;
  bfa_pkg::res_t              res;
  logic                       out_valid_r;
  bfa_pkg::res_t              out_res_r;

  logic            tbl_we, tbl_re;
  logic [IW-1:0]   tbl_waddr, tbl_raddr;
  bfa_pkg::entry_t tbl_wdata, tbl_rdata;

  // Configuration register, saturated to the pool capacity.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign wr_val     = ({15'd0, cfg_pwdata[bfa_pkg::SIZE_W-1:0]} > POOL_LIM) ?
                      POOL_LIM[bfa_pkg::SIZE_W-1:0] : cfg_pwdata[bfa_pkg::SIZE_W-1:0];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {15'd0, pool_size_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_RST;
    end else if (cfg_wr) begin
      pool_size_r <= wr_val;
    end
  end

  // Output register between the controller and the result channel.
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_res_r   <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  bfa_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .pool      (pool_size_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_cmd   (in_tuser[0]),
    .req_size  (in_tdata[16:0]),
    .req_offs  (in_tdata[32:17]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_re    (tbl_re),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata)
  );

  bfa_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

endmodule
`default_nettype wire

@@ rtl/bfa_checker.sv @@
`default_nettype none
module bfa_port_checks (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire        cfg_psel,
  input wire        cfg_penable,
  input wire        cfg_pwrite,
  input wire [2:0]  cfg_paddr
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A failed request never reports a granted offset.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[17:2] == 16'd0)
    else $error("granted offset on failed request");

  // Reset starts the clearing pass, so no item is taken next.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken right after reset");

  // A pool_size write restarts the clearing pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2] |=> !in_tready)
    else $error("item taken right after pool_size write");

endmodule

bind best_fit_block_allocator_top bfa_port_checks u_bfa_port_checks (.*);
`default_nettype wire
